/* hdl/ard_pkg.sv */
// Shared types and codes for the address region decoder.
// Used by ard_cell and address_region_decoder; depends on nothing.
package ard_pkg;

  localparam int MAX_REGIONS_DEF = 16;

  // Operation codes
  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_DECODE = 2'd1;
  localparam logic [1:0] MODE_RANGE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERLAP  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] address;
    logic [63:0] length;
    logic [2:0]  region_type;
    logic [7:0]  region_id;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  found_type;
    logic [7:0]  found_id;
    logic [63:0] region_offset;
    logic [63:0] found_size;
  } out_beat_t;

  // Current item, broadcast to every cell during a walk
  typedef struct packed {
    logic [63:0] addr_a;   // decode address, range start, or new base
    logic [63:0] addr_b;   // last byte of range
    logic [63:0] new_end;  // base + size of region being added
    logic [63:0] length;
    logic [2:0]  rtype;
    logic [7:0]  rid;
  } item_t;

  // Best candidate region seen so far for one lookup
  typedef struct packed {
    logic        vld;
    logic [63:0] base;
    logic [63:0] limit;
    logic [63:0] size;
    logic [2:0]  rtype;
    logic [7:0]  rid;
  } match_t;

  // Partial result handed from cell to cell
  typedef struct packed {
    match_t a;
    match_t b;
    logic   overlap;
    logic   free_vld;
  } token_t;

endpackage

/* hdl/ard_cell.sv */
// One table slot of the region decoder chain: holds an entry and folds it
// into the partial result passing through. Depends on ard_pkg.
module ard_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  ard_pkg::item_t  item,
  input  logic            step_in,
  input  ard_pkg::token_t tok_in,
  input  logic            commit,
  output logic            step_out,
  output ard_pkg::token_t tok_out
);

  logic            valid_r;
  logic            claim_r;
  logic            step_r;
  logic [63:0]     base_r;
  logic [63:0]     end_r;
  logic [63:0]     size_r;
  logic [2:0]      type_r;
  logic [7:0]      id_r;
  ard_pkg::token_t tok_r;
  ard_pkg::token_t tok_nxt;
  ard_pkg::match_t mine;
  logic            hit_a;
  logic            hit_b;
  logic            ovl;
  logic            claim_nxt;

  // Compare this entry against the token
  always_comb begin
    mine.vld      = 1'b1;
    mine.base     = base_r;
    mine.limit    = end_r;
    mine.size     = size_r;
    mine.rtype    = type_r;
    mine.rid      = id_r;

    // greatest base not above the address; earlier slot wins ties
    hit_a = valid_r && (base_r <= item.addr_a) &&
            (!tok_in.a.vld || (base_r > tok_in.a.base));
    hit_b = valid_r && (base_r <= item.addr_b) &&
            (!tok_in.b.vld || (base_r > tok_in.b.base));
    ovl   = valid_r && (item.addr_a < end_r) && (item.new_end > base_r);
    // first free slot in chain order claims the add
    claim_nxt = !valid_r && !tok_in.free_vld;

    tok_nxt          = tok_in;
    tok_nxt.overlap  = tok_in.overlap | ovl;
    tok_nxt.free_vld = tok_in.free_vld | !valid_r;
    if (hit_a) begin
      tok_nxt.a = mine;
    end
    if (hit_b) begin
      tok_nxt.b = mine;
    end
  end

  // Control: step marker, claim flag, entry valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 1'b0;
      claim_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      step_r <= step_in;
      if (step_in) begin
        claim_r <= claim_nxt;
      end
      if (commit && claim_r) begin
        valid_r <= 1'b1;
      end
    end
  end

  // Payload: token stage and entry fields
  always_ff @(posedge clk) begin
    if (step_in) begin
      tok_r <= tok_nxt;
    end
    if (commit && claim_r) begin
      base_r <= item.addr_a;
      end_r  <= item.new_end;
      size_r <= item.length;
      type_r <= item.rtype;
      id_r   <= item.rid;
    end
  end

  assign step_out = step_r;
  assign tok_out  = tok_r;

endmodule

/* hdl/address_region_decoder.sv */
// Address region decoder: region table as a chain of MAX_REGIONS cells.
// The partial result walks the cell chain one slot per cycle, then one finish
// stage forms the result beat. A new input beat is held off until the walk of
// the current item ends, and a stalled result holds off the next input beat.
// Reset (rst_n, synchronous): all table entries invalid, channels idle.
// Depends on ard_pkg and ard_cell.
module address_region_decoder #(
  parameter int MAX_REGIONS = ard_pkg::MAX_REGIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ard_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ard_pkg::out_beat_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_t;

  state_t             state_r;
  logic               start_r;
  logic [1:0]         mode_r;
  ard_pkg::item_t     item_r;
  logic               out_valid_r;
  ard_pkg::out_beat_t out_r;
  ard_pkg::out_beat_t res;
  logic               in_acc;
  logic               commit;
  logic               hit_a;
  logic               hit_b;
  ard_pkg::token_t    tok [MAX_REGIONS+1];
  logic               step [MAX_REGIONS+1];

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // Empty token enters the chain head
  assign tok[0]  = '0;
  assign step[0] = start_r;

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    ard_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .item     (item_r),
      .step_in  (step[i]),
      .tok_in   (tok[i]),
      .commit   (commit),
      .step_out (step[i+1]),
      .tok_out  (tok[i+1])
    );
  end

  // Finish stage: turn the final token into a result
  always_comb begin
    hit_a = tok[MAX_REGIONS].a.vld && (item_r.addr_a < tok[MAX_REGIONS].a.limit);
    hit_b = tok[MAX_REGIONS].b.vld && (item_r.addr_b < tok[MAX_REGIONS].b.limit);
    res   = '0;
    res.status = ard_pkg::ST_UNMAPPED;
    case (mode_r)
      ard_pkg::MODE_ADD: begin
        if (tok[MAX_REGIONS].overlap) begin
          res.status = ard_pkg::ST_OVERLAP;
        end else if (!tok[MAX_REGIONS].free_vld) begin
          res.status = ard_pkg::ST_FULL;
        end else begin
          res.status = ard_pkg::ST_OK;
        end
      end
      ard_pkg::MODE_DECODE: begin
        if (hit_a) begin
          res.status        = ard_pkg::ST_OK;
          res.found_type    = tok[MAX_REGIONS].a.rtype;
          res.found_id      = tok[MAX_REGIONS].a.rid;
          res.region_offset = item_r.addr_a - tok[MAX_REGIONS].a.base;
          res.found_size    = tok[MAX_REGIONS].a.size;
        end
      end
      ard_pkg::MODE_RANGE: begin
        if (item_r.length == 64'd0) begin
          res.status = ard_pkg::ST_OK;
        end else if (hit_a && hit_b &&
                     (tok[MAX_REGIONS].a.rtype == tok[MAX_REGIONS].b.rtype) &&
                     (tok[MAX_REGIONS].a.rid == tok[MAX_REGIONS].b.rid)) begin
          res.status = ard_pkg::ST_OK;
        end
      end
      default: begin
        res.status = ard_pkg::ST_UNMAPPED;
      end
    endcase
  end

  // Write the claimed slot on a successful add
  assign commit = step[MAX_REGIONS] && (mode_r == ard_pkg::MODE_ADD) &&
                  !tok[MAX_REGIONS].overlap && tok[MAX_REGIONS].free_vld;

  // Control: sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= in_acc;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          if (step[MAX_REGIONS]) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: item capture and result register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r         <= in_data.mode;
      item_r.addr_a  <= in_data.address;
      item_r.addr_b  <= in_data.address + in_data.length - 64'd1;
      item_r.new_end <= in_data.address + in_data.length;
      item_r.length  <= in_data.length;
      item_r.rtype   <= in_data.region_type;
      item_r.rid     <= in_data.region_id;
    end
    if (step[MAX_REGIONS]) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
